@@ hw/rtl/sri_pkg.sv @@
package sri_pkg;

  localparam int unsigned DLY_W  = 8;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned BIN_W  = 3;
  localparam int unsigned PH_W   = 2;
  localparam int unsigned COIL_W = 6;
  localparam int unsigned IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_MIN_DELAY     = 3'd0;
  localparam logic [IDX_W-1:0] REG_MAX_DELAY     = 3'd1;
  localparam logic [IDX_W-1:0] REG_RAMP_STEPS    = 3'd2;
  localparam logic [IDX_W-1:0] REG_HALF_STEPS    = 3'd3;
  localparam logic [IDX_W-1:0] REG_QUARTER_STEPS = 3'd4;
  localparam logic [IDX_W-1:0] REG_HALF_DECEL    = 3'd5;
  localparam logic [IDX_W-1:0] REG_QUARTER_DECEL = 3'd6;

  localparam logic [DLY_W-1:0] RST_MIN_DELAY     = 8'd6;
  localparam logic [DLY_W-1:0] RST_MAX_DELAY     = 8'd20;
  localparam logic [CNT_W-1:0] RST_RAMP_STEPS    = 8'd20;
  localparam logic [CNT_W-1:0] RST_HALF_STEPS    = 8'd100;
  localparam logic [CNT_W-1:0] RST_QUARTER_STEPS = 8'd50;
  localparam logic [CNT_W-1:0] RST_HALF_DECEL    = 8'd89;
  localparam logic [CNT_W-1:0] RST_QUARTER_DECEL = 8'd39;

  localparam logic [BIN_W-1:0] KICK_BIN = 3'd5;
  localparam logic             MODE_MOVE = 1'b0;
  localparam logic             MODE_HOME = 1'b1;

  typedef struct packed {
    logic [DLY_W-1:0] min_delay;
    logic [DLY_W-1:0] max_delay;
    logic [CNT_W-1:0] ramp_steps;
    logic [CNT_W-1:0] half_steps;
    logic [CNT_W-1:0] quarter_steps;
    logic [CNT_W-1:0] half_decel;
    logic [CNT_W-1:0] quarter_decel;
  } cfg_t;

  typedef struct packed {
    logic [PH_W-1:0]  phase;
    logic [CNT_W-1:0] count;
    logic [DLY_W-1:0] delay;
  } state_t;

  typedef struct packed {
    logic [COIL_W-1:0] coil;
    logic [PH_W-1:0]   phase;
    logic [BIN_W-1:0]  new_bin;
    logic [DLY_W-1:0]  delay;
    logic              done;
    logic              kick;
  } result_t;

  function automatic logic [COIL_W-1:0] coil_of(input logic [PH_W-1:0] ph);
    logic [COIL_W-1:0] c;
    unique case (ph)
      2'd0: c = 6'h1B;
      2'd1: c = 6'h1D;
      2'd2: c = 6'h2D;
      2'd3: c = 6'h2B;
      default: c = 6'h1B;
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/sri_core.sv @@
module sri_core
  import sri_pkg::*;
(
  input  cfg_t             cfg,
  input  state_t           st,
  input  logic             mode,
  input  logic [BIN_W-1:0] target_bin,
  input  logic [BIN_W-1:0] current_bin,
  input  logic             hall_hit,
  output state_t           st_nxt,
  output result_t          res
);

  always_comb begin
    logic signed [3:0] diff;
    logic              half;
    logic              back_q;
    logic              fwd_q;
    logic              fwd;
    logic [CNT_W-1:0]  len;
    logic [CNT_W-1:0]  dec;
    logic signed [9:0] d;
    logic [CNT_W:0]    n;
    logic [PH_W-1:0]   ph;
    logic              mv_done;

    diff   = signed'({1'b0, current_bin}) - signed'({1'b0, target_bin});
    half   = (diff == 4'sd2) || (diff == -4'sd2);
    back_q = (diff == 4'sd3) || (diff == -4'sd1);
    fwd_q  = (diff == 4'sd1) || (diff == -4'sd3);
    fwd    = fwd_q;
    len    = half ? cfg.half_steps : cfg.quarter_steps;
    dec    = half ? cfg.half_decel : cfg.quarter_decel;

    // trapezoid: accelerate, then decelerate, each clamped
    d = signed'({2'b00, st.delay});
    if (st.count < cfg.ramp_steps) begin
      d = d - 10'sd2;
      if (d < signed'({2'b00, cfg.min_delay})) begin
        d = signed'({2'b00, cfg.min_delay});
      end
    end
    if (st.count > dec) begin
      d = d + 10'sd2;
      if (d > signed'({2'b00, cfg.max_delay})) begin
        d = signed'({2'b00, cfg.max_delay});
      end
    end

    n       = {1'b0, st.count};
    ph      = st.phase;
    mv_done = 1'b0;
    if (n <= {1'b0, len}) begin
      ph = fwd ? st.phase + 2'd1 : st.phase + 2'd3;
      n  = n + 9'd1;
    end
    if (n >= {1'b0, len}) begin
      n       = '0;
      mv_done = 1'b1;
    end

    st_nxt      = st;
    res.done    = 1'b0;
    res.kick    = 1'b0;
    res.new_bin = current_bin;
    priority if (mode == MODE_HOME) begin
      if (hall_hit) begin
        res.done = 1'b1;
      end else begin
        st_nxt.phase = st.phase + 2'd1;
      end
    end else if (target_bin == KICK_BIN) begin
      res.kick = 1'b1;
    end else if (half || back_q || fwd_q) begin
      st_nxt.phase = ph;
      st_nxt.count = n[CNT_W-1:0];
      st_nxt.delay = d[DLY_W-1:0];
      res.done     = mv_done;
      if (mv_done) begin
        res.new_bin = target_bin;
      end
    end else begin
      st_nxt = st;
    end
    res.phase = st_nxt.phase;
    res.delay = st_nxt.delay;
    res.coil  = coil_of(st_nxt.phase);
  end

endmodule

@@ hw/rtl/stepper_ramped_indexer.sv @@
// The result of an accepted word is registered and shows at the output from the next cycle.
// Throughput: one word per cycle while out_ready holds; a new word enters while the previous result is taken.
// The output register holds a result until out_ready takes it; in_ready follows it.
// Reset (synchronous, rst_n low): registers to defaults, phase 0, count 0, delay 20,
// output register empty.
module stepper_ramped_indexer
  import sri_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [7:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  input  logic [BIN_W-1:0]  in_target_bin,
  input  logic [BIN_W-1:0]  in_current_bin,
  input  logic              in_hall_hit,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [COIL_W-1:0] out_coil_pattern,
  output logic [PH_W-1:0]   out_phase,
  output logic [BIN_W-1:0]  out_new_bin,
  output logic [DLY_W-1:0]  out_step_delay,
  output logic              out_move_done,
  output logic              out_kick_part
);

  cfg_t    cfg_r;
  state_t  st_r;
  state_t  st_nxt;
  result_t res_nxt;
  result_t res_r;
  logic    out_valid_r;
  logic    in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  sri_core u_core (
    .cfg         (cfg_r),
    .st          (st_r),
    .mode        (in_mode),
    .target_bin  (in_target_bin),
    .current_bin (in_current_bin),
    .hall_hit    (in_hall_hit),
    .st_nxt      (st_nxt),
    .res         (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_delay     <= RST_MIN_DELAY;
      cfg_r.max_delay     <= RST_MAX_DELAY;
      cfg_r.ramp_steps    <= RST_RAMP_STEPS;
      cfg_r.half_steps    <= RST_HALF_STEPS;
      cfg_r.quarter_steps <= RST_QUARTER_STEPS;
      cfg_r.half_decel    <= RST_HALF_DECEL;
      cfg_r.quarter_decel <= RST_QUARTER_DECEL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_DELAY:     cfg_r.min_delay     <= cfg_wdata;
        REG_MAX_DELAY:     cfg_r.max_delay     <= cfg_wdata;
        REG_RAMP_STEPS:    cfg_r.ramp_steps    <= cfg_wdata;
        REG_HALF_STEPS:    cfg_r.half_steps    <= cfg_wdata;
        REG_QUARTER_STEPS: cfg_r.quarter_steps <= cfg_wdata;
        REG_HALF_DECEL:    cfg_r.half_decel    <= cfg_wdata;
        REG_QUARTER_DECEL: cfg_r.quarter_decel <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase  <= '0;
      st_r.count  <= '0;
      st_r.delay  <= RST_MAX_DELAY;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_coil_pattern = res_r.coil;
  assign out_phase        = res_r.phase;
  assign out_new_bin      = res_r.new_bin;
  assign out_step_delay   = res_r.delay;
  assign out_move_done    = res_r.done;
  assign out_kick_part    = res_r.kick;

`ifndef SYNTHESIS
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted word produced no result");

  a_idle_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(st_r))
    else $error("state moved without an accepted word");

  a_kick_no_motion: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_mode == MODE_MOVE && in_target_bin == KICK_BIN
      |=> out_kick_part && !out_move_done && $stable(st_r))
    else $error("kick request disturbed the motor");

  a_phase_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_phase == st_r.phase)
    else $error("reported phase differs from motor phase");
`endif

endmodule

@@ verif/tb_stepper_ramped_indexer.sv @@
module tb_stepper_ramped_indexer;
  import sri_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [23:0] COIL_BITS = {6'h2B, 6'h2D, 6'h1D, 6'h1B};

  typedef struct packed {
    logic             mode;
    logic [BIN_W-1:0] tgt;
    logic [BIN_W-1:0] cur;
    logic             hall;
  } step_req_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [7:0]        cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_mode = 1'b0;
  logic [BIN_W-1:0]  in_target_bin = '0;
  logic [BIN_W-1:0]  in_current_bin = '0;
  logic              in_hall_hit = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [COIL_W-1:0] out_coil_pattern;
  logic [PH_W-1:0]   out_phase;
  logic [BIN_W-1:0]  out_new_bin;
  logic [DLY_W-1:0]  out_step_delay;
  logic              out_move_done;
  logic              out_kick_part;

  step_req_t pending_words[$];
  result_t   due_results[$];
  logic      in_took = 1'b0;
  logic      no_gaps = 1'b0;
  int        bad_results = 0;
  int        cycles = 0;

  logic [7:0]       mdl_regs [0:6];
  logic [PH_W-1:0]  mdl_phase;
  logic [CNT_W-1:0] mdl_count;
  logic [DLY_W-1:0] mdl_delay;

  stepper_ramped_indexer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_target_bin    (in_target_bin),
    .in_current_bin   (in_current_bin),
    .in_hall_hit      (in_hall_hit),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_coil_pattern (out_coil_pattern),
    .out_phase        (out_phase),
    .out_new_bin      (out_new_bin),
    .out_step_delay   (out_step_delay),
    .out_move_done    (out_move_done),
    .out_kick_part    (out_kick_part)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic advance_move(input logic fwd, input logic [7:0] len,
                                        input logic [7:0] decel_after);
    int   d;
    int   n;
    logic done;
    d = int'(mdl_delay);
    n = int'(mdl_count);
    done = 1'b0;
    if (mdl_count < mdl_regs[REG_RAMP_STEPS]) begin
      d = d - 2;
      if (d < int'(mdl_regs[REG_MIN_DELAY])) d = int'(mdl_regs[REG_MIN_DELAY]);
    end
    if (mdl_count > decel_after) begin
      d = d + 2;
      if (d > int'(mdl_regs[REG_MAX_DELAY])) d = int'(mdl_regs[REG_MAX_DELAY]);
    end
    mdl_delay = d[7:0];
    if (n <= int'(len)) begin
      mdl_phase = fwd ? mdl_phase + 2'd1 : mdl_phase + 2'd3;
      n = n + 1;
    end
    if (n >= int'(len)) begin
      n = 0;
      done = 1'b1;
    end
    mdl_count = n[7:0];
    return done;
  endfunction

  function automatic result_t predict_request(input step_req_t r);
    result_t res;
    int      diff;
    logic    done;
    logic    kick;
    done = 1'b0;
    kick = 1'b0;
    res.new_bin = r.cur;
    if (r.mode == MODE_HOME) begin
      if (r.hall) done = 1'b1;
      else mdl_phase = mdl_phase + 2'd1;
    end else if (r.tgt == KICK_BIN) begin
      kick = 1'b1;
    end else begin
      diff = int'(r.cur) - int'(r.tgt);
      if (diff == 2 || diff == -2)
        done = advance_move(1'b0, mdl_regs[REG_HALF_STEPS], mdl_regs[REG_HALF_DECEL]);
      else if (diff == 3 || diff == -1)
        done = advance_move(1'b0, mdl_regs[REG_QUARTER_STEPS], mdl_regs[REG_QUARTER_DECEL]);
      else if (diff == 1 || diff == -3)
        done = advance_move(1'b1, mdl_regs[REG_QUARTER_STEPS], mdl_regs[REG_QUARTER_DECEL]);
      if (done) res.new_bin = r.tgt;
    end
    res.coil  = COIL_BITS[mdl_phase*6 +: 6];
    res.phase = mdl_phase;
    res.delay = mdl_delay;
    res.done  = done;
    res.kick  = kick;
    return res;
  endfunction

  always @(negedge clk) begin
    step_req_t w;
    if (!in_valid || in_took) begin
      if (pending_words.size() != 0 && (no_gaps || $urandom_range(99) >= 35)) begin
        w = pending_words.pop_front();
        in_valid       <= 1'b1;
        in_mode        <= w.mode;
        in_target_bin  <= w.tgt;
        in_current_bin <= w.cur;
        in_hall_hit    <= w.hall;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= no_gaps || ($urandom_range(99) >= 35);
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("stepper_ramped_indexer: mismatch");
      $finish;
    end else begin
      in_took <= in_valid && in_ready;
      if (rst_n) begin
        if (out_valid && out_ready) begin
          got = '{out_coil_pattern, out_phase, out_new_bin, out_step_delay,
                  out_move_done, out_kick_part};
          if (due_results.size() == 0) begin
            if (bad_results < 10)
              $display("unexpected word: coil %h phase %0d bin %0d delay %0d done %b kick %b",
                       got.coil, got.phase, got.new_bin, got.delay, got.done, got.kick);
            bad_results = bad_results + 1;
          end else begin
            want = due_results.pop_front();
            if (got.coil !== want.coil || got.phase !== want.phase ||
                got.new_bin !== want.new_bin || got.delay !== want.delay ||
                got.done !== want.done || got.kick !== want.kick) begin
              if (bad_results < 10) begin
                $display("exp coil %h phase %0d bin %0d delay %0d done %b kick %b",
                         want.coil, want.phase, want.new_bin, want.delay, want.done,
                         want.kick);
                $display("got coil %h phase %0d bin %0d delay %0d done %b kick %b",
                         got.coil, got.phase, got.new_bin, got.delay, got.done,
                         got.kick);
              end
              bad_results = bad_results + 1;
            end
          end
        end
        if (in_valid && in_ready)
          due_results.push_back(predict_request('{in_mode, in_target_bin,
                                                  in_current_bin, in_hall_hit}));
      end
    end
  end

  task automatic push_req(input logic mode, input logic [2:0] tgt, input logic [2:0] cur,
                          input logic hall);
    step_req_t w;
    w = '{mode, tgt, cur, hall};
    pending_words.push_back(w);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    mdl_regs[idx] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_regs(input logic [7:0] mn, input logic [7:0] mx, input logic [7:0] rmp,
                           input logic [7:0] hs, input logic [7:0] qs, input logic [7:0] hd,
                           input logic [7:0] qd);
    write_reg(REG_MIN_DELAY, mn);
    write_reg(REG_MAX_DELAY, mx);
    write_reg(REG_RAMP_STEPS, rmp);
    write_reg(REG_HALF_STEPS, hs);
    write_reg(REG_QUARTER_STEPS, qs);
    write_reg(REG_HALF_DECEL, hd);
    write_reg(REG_QUARTER_DECEL, qd);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_words.size() != 0 || in_valid || due_results.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic add_random(input int n);
    int         made;
    int         k;
    int         reps;
    int         len;
    logic [2:0] cur;
    logic [2:0] off;
    made = 0;
    while (made < n) begin
      k = $urandom_range(99);
      if (k < 60) begin
        cur = 3'($urandom_range(3));
        off = 3'($urandom_range(1, 3));
        len = (off == 3'd2) ? int'(mdl_regs[REG_HALF_STEPS])
                            : int'(mdl_regs[REG_QUARTER_STEPS]);
        if ($urandom_range(3) == 0) reps = $urandom_range(1, len);
        else reps = len + $urandom_range(0, 2);
        for (int i = 0; i < reps; i++)
          push_req(MODE_MOVE, (cur + off) & 3'd3, cur, 1'($urandom_range(1)));
        made = made + reps;
      end else if (k < 70) begin
        push_req(MODE_MOVE, KICK_BIN, 3'($urandom_range(5)), 1'($urandom_range(1)));
        made = made + 1;
      end else if (k < 82) begin
        reps = $urandom_range(0, 6);
        for (int i = 0; i < reps; i++)
          push_req(MODE_HOME, 3'($urandom_range(5)), 3'($urandom_range(5)), 1'b0);
        push_req(MODE_HOME, 3'($urandom_range(5)), 3'($urandom_range(5)), 1'b1);
        made = made + reps + 1;
      end else begin
        push_req(1'($urandom_range(1)), 3'($urandom_range(5)), 3'($urandom_range(5)),
                 1'($urandom_range(1)));
        made = made + 1;
      end
    end
  endtask

  initial begin
    logic [7:0] mn;
    mdl_regs[REG_MIN_DELAY]     = RST_MIN_DELAY;
    mdl_regs[REG_MAX_DELAY]     = RST_MAX_DELAY;
    mdl_regs[REG_RAMP_STEPS]    = RST_RAMP_STEPS;
    mdl_regs[REG_HALF_STEPS]    = RST_HALF_STEPS;
    mdl_regs[REG_QUARTER_STEPS] = RST_QUARTER_STEPS;
    mdl_regs[REG_HALF_DECEL]    = RST_HALF_DECEL;
    mdl_regs[REG_QUARTER_DECEL] = RST_QUARTER_DECEL;
    mdl_phase = '0;
    mdl_count = '0;
    mdl_delay = RST_MAX_DELAY;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_req(MODE_MOVE, KICK_BIN, 3'd0, 1'b1);
    push_req(MODE_MOVE, KICK_BIN, 3'd5, 1'b0);
    push_req(MODE_MOVE, 3'd2, 3'd2, 1'b0);
    push_req(MODE_MOVE, 3'd0, 3'd4, 1'b0);
    push_req(MODE_MOVE, 3'd4, 3'd0, 1'b1);
    push_req(MODE_HOME, 3'd0, 3'd0, 1'b0);
    push_req(MODE_HOME, 3'd5, 3'd5, 1'b0);
    push_req(MODE_HOME, 3'd5, 3'd5, 1'b1);
    push_req(MODE_MOVE, 3'd2, 3'd0, 1'b0);
    push_req(MODE_MOVE, 3'd2, 3'd0, 1'b0);
    push_req(MODE_MOVE, 3'd2, 3'd0, 1'b1);
    push_req(MODE_MOVE, 3'd3, 3'd1, 1'b0);
    push_req(MODE_MOVE, 3'd0, 3'd3, 1'b0);
    push_req(MODE_MOVE, 3'd2, 3'd1, 1'b0);
    push_req(MODE_MOVE, 3'd1, 3'd2, 1'b0);
    push_req(MODE_MOVE, 3'd3, 3'd0, 1'b0);
    push_req(MODE_MOVE, 3'd3, 3'd5, 1'b0);
    push_req(MODE_MOVE, 3'd4, 3'd5, 1'b0);
    drain();
    write_reg(REG_QUARTER_STEPS, 8'd2);
    push_req(MODE_MOVE, 3'd1, 3'd2, 1'b0);
    push_req(MODE_MOVE, 3'd1, 3'd2, 1'b0);
    drain();
    write_reg(REG_QUARTER_STEPS, RST_QUARTER_STEPS);
    add_random(330);
    drain();

    load_regs(8'd1, 8'd255, 8'd0, 8'd1, 8'd1, 8'd0, 8'd0);
    add_random(200);
    drain();

    load_regs(8'd255, 8'd1, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    add_random(450);
    drain();

    no_gaps = 1'b1;
    mn = 8'($urandom_range(1, 20));
    load_regs(mn, 8'($urandom_range(1, 60)), 8'($urandom_range(0, 60)),
              8'($urandom_range(1, 80)), 8'($urandom_range(1, 40)),
              8'($urandom_range(0, 80)), 8'($urandom_range(0, 40)));
    add_random(250);
    drain();
    no_gaps = 1'b0;

    load_regs(8'($urandom_range(1, 40)), 8'($urandom_range(1, 40)),
              8'($urandom_range(0, 255)), 8'($urandom_range(1, 60)),
              8'($urandom_range(1, 30)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 30)));
    add_random(250);
    drain();

    if (due_results.size() != 0) bad_results = bad_results + 1;
    if (bad_results == 0) begin
      $display("stepper_ramped_indexer: match");
    end else begin
      $display("stepper_ramped_indexer: mismatch");
    end
    $finish;
  end

endmodule
